FILE: design/lgtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgtm_pkg
// types, constants and table builders for the luminance gamma tone mapper
// ----------------------------------------------------------------------------
package lgtm_pkg;

	localparam int unsigned LOG_ENTRIES = 256;
	localparam int unsigned LOG_IDX_W   = 8;
	localparam int unsigned EXP_STEPS   = 16;
	localparam int unsigned DIV_BITS    = 17;

	localparam logic [15:0] LUMA_R = 16'd13933;
	localparam logic [15:0] LUMA_G = 16'd46871;
	localparam logic [15:0] LUMA_B = 16'd4732;

	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [30:0] MANT_ONE = 31'h4000_0000;

	// register indexes of the config port
	localparam logic [1:0] REG_GAIN    = 2'd0;
	localparam logic [1:0] REG_GAMMA   = 2'd1;
	localparam logic [1:0] REG_EPSILON = 2'd2;

	// per-pixel data that rides along the pipe
	typedef struct packed {
		logic             last;
		logic             dark;
		logic [23:0]      lum;
		logic [2:0][23:0] chan;
		logic [2:0][16:0] dclamp;
	} side_t;

	// log2(1 + k/LOG_ENTRIES) in q0.16 by repeated squaring
	function automatic logic [16:0] log_entry(input int unsigned k);
		logic [63:0] v;
		logic [16:0] r;
		v = (64'd1 << 30) + ((64'(k) << 30) / LOG_ENTRIES);
		r = '0;
		for (int j = 0; j < 16; j++) begin
			v = (v * v) >> 30;
			r = r << 1;
			if (v >= (64'd1 << 31)) begin
				r[0] = 1'b1;
				v = v >> 1;
			end
		end
		if (k >= LOG_ENTRIES) begin
			r = ONE_Q16;
		end
		return r;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = val;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-k) in q1.30
	function automatic logic [31:0] root_const(input int unsigned k);
		logic [63:0] c;
		c = 64'd1 << 31;
		for (int unsigned i = 1; i <= k; i++) begin
			c = isqrt64(c << 30);
		end
		return c[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: design/luminance_gamma_tone_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// luminance_gamma_tone_map
// hdr rgb pixel in, luminance-preserving gain * L^gamma tone map, q1.16 out
// ----------------------------------------------------------------------------
// channel   direction  word
// s_axis    in         tdata = red, green, blue (q8.16 each), tlast = end of frame
// m_axis    out        tdata = red, green, blue (q1.16 each), tlast = end of frame
// cfg       in         cfg_index selects gain / gamma_exponent / epsilon
//
// one pixel per clock while the pipe is not stalled
// the depth is set by the 16-step exp2 multiply chain and the 17-step divider
// one stall signal freezes every stage when the output word is not taken
// arst_n clears valid bits and sets config registers to defaults, no clearing pass
// ----------------------------------------------------------------------------
module luminance_gamma_tone_map
	import lgtm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // red_in, green_in, blue_in
	input  wire logic        s_axis_tlast,  // frame_last
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,  // red_out, green_out, blue_out, zero pad
	output logic             m_axis_tlast,  // frame_last_out
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int NST = 47;

	// config registers
	logic [15:0] gain_q;
	logic [15:0] gamma_q;
	logic [23:0] epsilon_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= 16'd256;
			gamma_q   <= 16'd4096;
			epsilon_q <= 24'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAIN:    gain_q    <= cfg_data[15:0];
				REG_GAMMA:   gamma_q   <= cfg_data[15:0];
				REG_EPSILON: epsilon_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: the whole pipe moves unless the output word is stuck
	logic           adv;
	logic [NST:1]   vld_q;

	assign adv           = ~vld_q[NST] | m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-1:1], s_axis_tvalid};
		end
	end

	// constant tables
	logic [16:0] log_rom [0:LOG_ENTRIES];
	logic [31:0] root_c  [1:EXP_STEPS];

	for (genvar gk = 0; gk <= LOG_ENTRIES; gk++) begin : g_log
		assign log_rom[gk] = log_entry(gk);
	end
	for (genvar gr = 1; gr <= EXP_STEPS; gr++) begin : g_root
		assign root_c[gr] = root_const(gr);
	end

	// ---- pipeline registers ----
	logic [2:0][23:0] chan_s1, chan_s2, chan_s3;
	logic             last_s1, last_s2, last_s3;
	logic [39:0]      prod_r_s2, prod_g_s2, prod_b_s2;
	logic [23:0]      lum_s3;
	side_t            side_s [4:46];
	logic [4:0]       p_s4, p_s5, p_s6, p_s7;
	logic [LOG_IDX_W-1:0] idx_s5;
	logic [14:0]      frac_s5, frac_s6;
	logic [16:0]      t0_s6, t1_s6;
	logic [16:0]      lf_s7;
	logic signed [38:0] t_s8;

	// exp2 chain, index 0 is stage 9, index k is stage 9+k
	logic [30:0]        mant_se [0:EXP_STEPS];
	logic [15:0]        fp_se   [0:EXP_STEPS];
	logic signed [9:0]  ip_se   [0:EXP_STEPS];

	logic [17:0]        m16_s26;
	logic [2:0][39:0]   cg_s26;
	logic signed [9:0]  sh_s26, sh_s27;
	logic [2:0][57:0]   num_s27, num_s28, dn_s28;
	logic [2:0][40:0]   up_s28;
	logic [39:0]        thr_s28;
	logic               neg_s28, big_s28;

	// divider, index 0 is stage 29, index j is stage 29+j
	logic [2:0][40:0]   rem_sd [0:DIV_BITS];
	logic [2:0][16:0]   quo_sd [0:DIV_BITS];
	logic [2:0]         sat_sd [0:DIV_BITS];

	logic [2:0][16:0]   out_s47;
	logic               last_s47;

	// ---- combinational pieces ----
	logic [40:0] lum_sum;
	logic [4:0]  top_bit;
	logic [46:0] norm;
	logic [16:0] diff;
	logic [31:0] interp;
	logic [5:0]  pm16;
	logic signed [21:0] lg;
	logic signed [38:0] y_rnd;
	logic [63:0] exp_rnd [1:EXP_STEPS];
	logic [32:0] m16_sum;
	logic [5:0]  up_amt, dn_amt;
	logic [9:0]  neg_sh;
	logic [40:0] div_dv   [0:DIV_BITS-1];
	logic [2:0]  div_ge   [0:DIV_BITS-1];

	assign lum_sum = {1'b0, prod_r_s2} + {1'b0, prod_g_s2} + {1'b0, prod_b_s2}
		+ 41'd32768;

	// leading one of luminance
	always_comb begin
		top_bit = '0;
		for (int i = 0; i < 24; i++) begin
			if (lum_s3[i]) top_bit = 5'(i);
		end
	end

	assign norm   = 47'(side_s[4].lum) << (5'd23 - p_s4);
	assign diff   = t1_s6 - t0_s6;
	assign interp = 32'(diff) * 32'(frac_s6);
	assign pm16   = {1'b0, p_s7} - 6'd16;
	assign lg     = $signed({pm16, 16'b0}) + $signed({5'b0, lf_s7});
	assign y_rnd  = t_s8 + 39'sd2048;

	always_comb begin
		for (int k = 1; k <= EXP_STEPS; k++) begin
			exp_rnd[k] = ({33'b0, mant_se[k-1]} * {32'b0, root_c[k]})
				+ (64'd1 << 29);
		end
	end

	assign m16_sum = {2'b0, mant_se[EXP_STEPS]} + 33'd8192;

	// shift amounts for the scale by 2^(ip-8)
	assign neg_sh = -sh_s27;
	assign up_amt = ($signed(sh_s27) >= 10'sd41) ? 6'd41 : sh_s27[5:0];
	assign dn_amt = (neg_sh >= 10'd63) ? 6'd63 : neg_sh[5:0];

	// restoring divide, one quotient bit per stage
	always_comb begin
		for (int j = 0; j < DIV_BITS; j++) begin
			div_dv[j] = {17'b0, side_s[29+j].lum} << (DIV_BITS - 1 - j);
			for (int c = 0; c < 3; c++) begin
				div_ge[j][c] = rem_sd[j][c] >= div_dv[j];
			end
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: input word
			chan_s1[0] <= s_axis_tdata[23:0];
			chan_s1[1] <= s_axis_tdata[47:24];
			chan_s1[2] <= s_axis_tdata[71:48];
			last_s1    <= s_axis_tlast;

			// stage 2: rec.709 weights
			prod_r_s2 <= 40'(chan_s1[0]) * 40'(LUMA_R);
			prod_g_s2 <= 40'(chan_s1[1]) * 40'(LUMA_G);
			prod_b_s2 <= 40'(chan_s1[2]) * 40'(LUMA_B);
			chan_s2   <= chan_s1;
			last_s2   <= last_s1;

			// stage 3: luminance
			lum_s3  <= lum_sum[39:16];
			chan_s3 <= chan_s2;
			last_s3 <= last_s2;

			// stage 4: dark test, leading one, bypass values
			side_s[4].last <= last_s3;
			side_s[4].dark <= lum_s3 <= epsilon_q;
			side_s[4].lum  <= lum_s3;
			side_s[4].chan <= chan_s3;
			for (int c = 0; c < 3; c++) begin
				side_s[4].dclamp[c] <= (chan_s3[c] > 24'(ONE_Q16)) ? ONE_Q16
					: chan_s3[c][16:0];
			end
			p_s4 <= top_bit;

			for (int s = 5; s <= 46; s++) begin
				side_s[s] <= side_s[s-1];
			end

			// stage 5: normalize to the log table index and fraction
			idx_s5  <= norm[22:15];
			frac_s5 <= norm[14:0];
			p_s5    <= p_s4;

			// stage 6: table read
			t0_s6   <= log_rom[{1'b0, idx_s5}];
			t1_s6   <= log_rom[{1'b0, idx_s5} + 9'd1];
			frac_s6 <= frac_s5;
			p_s6    <= p_s5;

			// stage 7: linear interpolation
			lf_s7 <= t0_s6 + interp[31:15];
			p_s7  <= p_s6;

			// stage 8: log2(L) * gamma
			t_s8 <= 39'(lg) * $signed({23'b0, gamma_q});

			// stage 9: round back to q.16, split integer and fraction
			ip_se[0]   <= y_rnd[37:28];
			fp_se[0]   <= y_rnd[27:12];
			mant_se[0] <= MANT_ONE;

			// stages 10..25: one root multiply per fraction bit
			for (int k = 1; k <= EXP_STEPS; k++) begin
				ip_se[k] <= ip_se[k-1];
				fp_se[k] <= fp_se[k-1];
				if (fp_se[k-1][EXP_STEPS-k]) begin
					mant_se[k] <= exp_rnd[k][60:30];
				end else begin
					mant_se[k] <= mant_se[k-1];
				end
			end

			// stage 26: mantissa to q1.16, channel times gain
			m16_s26 <= m16_sum[31:14];
			sh_s26  <= ip_se[EXP_STEPS] - 10'sd8;
			for (int c = 0; c < 3; c++) begin
				cg_s26[c] <= 40'(side_s[25].chan[c]) * 40'(gain_q);
			end

			// stage 27: full numerator
			for (int c = 0; c < 3; c++) begin
				num_s27[c] <= 58'(cg_s26[c]) * 58'(m16_s26);
			end
			sh_s27 <= sh_s26;

			// stage 28: shifts
			neg_s28 <= sh_s27[9];
			big_s28 <= $signed(sh_s27) >= 10'sd41;
			thr_s28 <= {side_s[27].lum, 16'b0} >> up_amt;
			for (int c = 0; c < 3; c++) begin
				num_s28[c] <= num_s27[c];
				up_s28[c]  <= 41'(num_s27[c] << up_amt);
				dn_s28[c]  <= num_s27[c] >> dn_amt;
			end

			// stage 29: saturation test and dividend select
			for (int c = 0; c < 3; c++) begin
				if (neg_s28) begin
					sat_sd[0][c] <= dn_s28[c] > {18'b0, side_s[28].lum, 16'b0};
					rem_sd[0][c] <= dn_s28[c][40:0];
				end else begin
					sat_sd[0][c] <= big_s28 ? (num_s28[c] != '0)
						: (num_s28[c] > {18'b0, thr_s28});
					rem_sd[0][c] <= up_s28[c];
				end
				quo_sd[0][c] <= '0;
			end

			// stages 30..46: divide by luminance
			for (int j = 0; j < DIV_BITS; j++) begin
				sat_sd[j+1] <= sat_sd[j];
				for (int c = 0; c < 3; c++) begin
					rem_sd[j+1][c] <= div_ge[j][c] ? rem_sd[j][c] - div_dv[j]
						: rem_sd[j][c];
					quo_sd[j+1][c] <= {quo_sd[j][c][15:0], div_ge[j][c]};
				end
			end

			// stage 47: output word
			last_s47 <= side_s[46].last;
			for (int c = 0; c < 3; c++) begin
				if (side_s[46].dark) begin
					out_s47[c] <= side_s[46].dclamp[c];
				end else if (sat_sd[DIV_BITS][c]) begin
					out_s47[c] <= ONE_Q16;
				end else begin
					out_s47[c] <= quo_sd[DIV_BITS][c];
				end
			end
		end
	end

	assign m_axis_tdata = {5'b0, out_s47[2], out_s47[1], out_s47[0]};
	assign m_axis_tlast = last_s47;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the luminance gamma tone mapper: pixels go in on
// the slave stream, every output word is checked against a local model of
// the luminance, log2/exp2 gamma and per-channel scaling, across several
// gain / gamma / epsilon settings with random input gaps and output stalls
// ----------------------------------------------------------------------------
module tb_top;
	import lgtm_pkg::*;

	localparam int PIPE_LAT = 47;

	// tone-mapped pixel as it should appear on the master side
	typedef struct {
		logic [16:0] red;
		logic [16:0] green;
		logic [16:0] blue;
		logic        last;
	} mapped_px_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;   // red [23:0], green [47:24], blue [71:48]
	logic        s_axis_tlast = 1'b0; // end of frame
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;        // red [16:0], green [33:17], blue [50:34], pad
	logic        m_axis_tlast;        // end of frame
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_GAIN;
	logic [23:0] cfg_data = '0;

	luminance_gamma_tone_map dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// model copy of the config registers
	logic [15:0] cur_gain = 16'd256;
	logic [15:0] cur_gamma = 16'd4096;
	logic [23:0] cur_eps = 24'd1;

	// fixed tables: log2(1+k/256) q0.16 and 2^(2^-k) q1.30
	longint unsigned log2_rom [0:256];
	longint unsigned root_rom [0:16];

	mapped_px_t expected_px[$];
	int mismatches = 0;
	int words_seen = 0;
	int pixels_sent = 0;

	// sender burst state, receiver stall mode, long hold-off request
	int burst_left = 0;
	int stall_pct = 30;
	int hold_cycles = 0;

	function automatic longint unsigned int_sqrt(input longint unsigned val);
		longint unsigned v, r, b;
		v = val;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic build_roms();
		longint unsigned v, r;
		for (int k = 0; k < 256; k++) begin
			v = (64'd1 << 30) + ((64'(k) << 30) / 256);
			r = 0;
			for (int j = 0; j < 16; j++) begin
				v = (v * v) >> 30;
				r = r << 1;
				if (v >= (64'd1 << 31)) begin
					r = r | 1;
					v = v >> 1;
				end
			end
			log2_rom[k] = r;
		end
		log2_rom[256] = 65536;
		root_rom[0] = 64'd1 << 31;
		for (int k = 1; k <= 16; k++) root_rom[k] = int_sqrt(root_rom[k-1] << 30);
	endtask

	// channel * gain * 2^y / L, saturated at 1.0
	function automatic logic [16:0] scale_chan(input longint unsigned c,
			input longint unsigned m16, input longint s, input longint unsigned lum);
		longint unsigned num, q;
		num = c * cur_gain * m16;
		if (num == 0) return 0;
		if (s >= 0) begin
			if (s >= 41) return ONE_Q16;
			if (num > ((64'd65536 * lum) >> s)) return ONE_Q16;
			q = (num << s) / lum;
		end else begin
			if (-s >= 64) return 0;
			q = (num >> (-s)) / lum;
		end
		return (q > 65536) ? ONE_Q16 : q[16:0];
	endfunction

	function automatic mapped_px_t tone_map(input logic [23:0] r, input logic [23:0] g,
			input logic [23:0] b, input logic last);
		mapped_px_t o;
		longint unsigned lum, f, pos, idx, rem, lf, mant;
		longint lg, y, ip;
		int p;
		o.last = last;
		lum = (64'd13933 * r + 64'd46871 * g + 64'd4732 * b + 32768) >> 16;
		if (lum <= cur_eps) begin
			// dark pixel passes through, clamped to 1.0
			o.red   = (r > 65536) ? ONE_Q16 : r[16:0];
			o.green = (g > 65536) ? ONE_Q16 : g[16:0];
			o.blue  = (b > 65536) ? ONE_Q16 : b[16:0];
			return o;
		end
		p = 23;
		while (lum[p] == 1'b0) p--;
		f = (lum << (23 - p)) & 64'h7F_FFFF;
		pos = f * 256;
		idx = pos >> 23;
		rem = pos & 64'h7F_FFFF;
		lf = log2_rom[idx] + (((log2_rom[idx+1] - log2_rom[idx]) * rem) >> 23);
		lg = (longint'(p) - 16) * 65536 + longint'(lf);
		y = (lg * longint'(cur_gamma) + 2048) >>> 12;
		ip = y >>> 16;
		mant = 64'd1 << 30;
		for (int k = 1; k <= 16; k++)
			if (y[16-k]) mant = (mant * root_rom[k] + (64'd1 << 29)) >> 30;
		mant = (mant + (64'd1 << 13)) >> 14;
		o.red   = scale_chan(r, mant, ip - 8, lum);
		o.green = scale_chan(g, mant, ip - 8, lum);
		o.blue  = scale_chan(b, mant, ip - 8, lum);
		return o;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		mismatches++;
		$display("%0t mismatch word %0d %s: got %0d expected %0d",
			$realtime, words_seen, what, got, want);
	endtask

	// output checker, samples at the edge where the word is taken
	always @(posedge clk) begin
		mapped_px_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_px.size() == 0) begin
				report("unexpected word", m_axis_tdata[16:0], -1);
			end else begin
				w = expected_px.pop_front();
				if (m_axis_tdata[16:0] !== w.red) report("red", m_axis_tdata[16:0], w.red);
				if (m_axis_tdata[33:17] !== w.green)
					report("green", m_axis_tdata[33:17], w.green);
				if (m_axis_tdata[50:34] !== w.blue)
					report("blue", m_axis_tdata[50:34], w.blue);
				if (m_axis_tlast !== w.last) report("tlast", m_axis_tlast, w.last);
			end
			words_seen++;
		end
	end

	// receiver: long hold-off when asked, else random stalls at stall_pct
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// one pixel on the slave stream, with bursts and random gaps
	task automatic send_pixel(input logic [23:0] r, input logic [23:0] g,
			input logic [23:0] b, input logic last);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, g, r};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		expected_px.push_back(tone_map(r, g, b, last));
		pixels_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(40);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop offering and let every expected word drain plus the pipe depth
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_px.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GAIN: begin
				cur_gain = val[15:0];
			end
			REG_GAMMA: begin
				cur_gamma = val[15:0];
			end
			default: begin
				cur_eps = val;
			end
		endcase
	endtask

	task automatic set_mapping(input logic [15:0] gn, input logic [15:0] gm,
			input logic [23:0] ep);
		write_reg(REG_GAIN, {8'b0, gn});
		write_reg(REG_GAMMA, {8'b0, gm});
		write_reg(REG_EPSILON, ep);
	endtask

	// channel value: full range, up to 3.0, tiny, or around 1.0 where the mapping is interesting
	function automatic logic [23:0] rand_chan();
		case ($urandom_range(3))
			0: return 24'($urandom_range(24'hFF_FFFF));
			1: return 24'($urandom_range(24'h3_0000));
			2: return 24'($urandom_range(24'h400));
			default: return 24'($urandom_range(24'h1_8000, 24'h8000));
		endcase
	endfunction

	task automatic random_pixels(input int n);
		for (int i = 0; i < n; i++)
			send_pixel(rand_chan(), rand_chan(), rand_chan(), ($urandom_range(15) == 0));
	endtask

	// field extremes, dark threshold both sides, saturation
	task automatic test_directed();
		set_mapping(16'd256, 16'd4096, 24'd1);
		send_pixel(24'd0, 24'd0, 24'd0, 1'b0);
		send_pixel(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
		send_pixel(24'd1, 24'd1, 24'd1, 1'b0);
		send_pixel(24'd2, 24'd2, 24'd2, 1'b0);
		send_pixel(24'h1_0000, 24'h1_0000, 24'h1_0000, 1'b0);
		send_pixel(24'hFF_FFFF, 24'd0, 24'd0, 1'b0);
		send_pixel(24'd0, 24'hFF_FFFF, 24'd0, 1'b1);
		send_pixel(24'd0, 24'd0, 24'hFF_FFFF, 1'b0);
		send_pixel(24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 1'b1);
		drain();
		set_mapping(16'd512, 16'd2048, 24'h8000);
		send_pixel(24'h8000, 24'h8000, 24'h8000, 1'b0);      // at threshold
		send_pixel(24'h8001, 24'h8001, 24'h8001, 1'b0);      // just above
		send_pixel(24'h2_0000, 24'h0, 24'h0, 1'b1);          // dark, clamps red
		send_pixel(24'h4000, 24'h1_0000, 24'h2000, 1'b0);
		drain();
		set_mapping(16'd0, 16'd4096, 24'd0);                 // zero gain
		send_pixel(24'h1_0000, 24'h8000, 24'hFF_FFFF, 1'b0);
		send_pixel(24'd0, 24'd0, 24'd0, 1'b1);               // black, epsilon 0
		drain();
		set_mapping(16'd128, 16'd0, 24'd0);                  // zero gamma
		send_pixel(24'h1_0000, 24'h8000, 24'h4000, 1'b0);
		send_pixel(24'h10, 24'h20, 24'h30, 1'b1);
		drain();
	endtask

	// several register settings, extremes included
	task automatic test_settings();
		logic [15:0] gains [6] = '{16'd256, 16'hFFFF, 16'd0, 16'd1, 16'd300, 16'd64};
		logic [15:0] gams [6] = '{16'hFFFF, 16'd4096, 16'd1, 16'd0, 16'd1843, 16'd9000};
		logic [23:0] eps [6] = '{24'hFF_FFFF, 24'd0, 24'd1, 24'h100, 24'h10, 24'd0};
		for (int s = 0; s < 6; s++) begin
			set_mapping(gains[s], gams[s], eps[s]);
			random_pixels(80);
			drain();
		end
	endtask

	// long output hold-off while the sender keeps offering
	task automatic test_backpressure();
		set_mapping(16'd256, 16'd2867, 24'h40);
		hold_cycles = 200;
		burst_left = 500;
		random_pixels(150);
		drain();
	endtask

	// random settings, random pixels, stall mode varied per block
	task automatic test_random();
		for (int blk = 0; blk < 10; blk++) begin
			set_mapping(16'($urandom_range(16'hFFFF) >> $urandom_range(8)),
				16'($urandom_range(16'hFFFF) >> $urandom_range(4)),
				24'($urandom_range(24'hFF_FFFF) >> $urandom_range(24, 8)));
			stall_pct = (blk % 3 == 0) ? 0 : $urandom_range(60);
			random_pixels(80);
			drain();
		end
		stall_pct = 30;
	endtask

	initial begin
		build_roms();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		test_backpressure();
		test_random();
		drain();
		$display("covered %0d pixels, %0d output words, directed cases and 17 settings",
			pixels_sent, words_seen);
		$display("including gain/gamma/epsilon extremes and a long output hold-off");
		if (mismatches == 0 && expected_px.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout with %0d words outstanding", expected_px.size());
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: luminance_gamma_tone_map.f
design/lgtm_pkg.sv
design/luminance_gamma_tone_map.sv
tb/tb_top.sv
